// ===== rtl/core/two_voice_sample_mixer_core_macros.svh =====
// assertion macros for the two-voice sample mixer core
`ifndef TWO_VOICE_SAMPLE_MIXER_CORE_MACROS_SVH
`define TWO_VOICE_SAMPLE_MIXER_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define TVSM_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TVSM_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tvsm_pkg.sv =====
// shared constants and codes for the two-voice sample mixer core
`timescale 1ns / 1ps
package tvsm_pkg;

	localparam int DEF_STORE_DEPTH = 16384;

	localparam int SAMPLE_W   = 16;
	localparam int ADDR_IN_W  = 14;
	localparam int LEN_W      = 15;
	localparam int VOL_W      = 7;
	localparam int ACT_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 2;

	localparam logic [ACT_W-1:0] ACT_TICK         = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START_MUSIC  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_STOP_MUSIC   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_PLAY_EFFECT  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_STOP_EFFECT  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_STOP_ALL     = 3'd5;
	localparam logic [ACT_W-1:0] ACT_LOAD_SAMPLE  = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_VOLUME  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_VOLUME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_BASE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_LENGTH  = 2'd3;

	localparam logic [VOL_W-1:0] RST_MUSIC_VOLUME  = 7'd50;
	localparam logic [VOL_W-1:0] RST_EFFECT_VOLUME = 7'd80;
	localparam logic [LEN_W-1:0] RST_MUSIC_LENGTH  = 15'd16384;

	// scaled product and divide by 100 through a reciprocal
	localparam int PROD_W      = SAMPLE_W + VOL_W + 1;
	localparam int MAG_W       = PROD_W - 1;
	localparam int RECIP_W     = 23;
	localparam int RECIP_SHIFT = 29;
	localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;
	localparam int QUOT_W      = 16;
	localparam int MIX_W       = QUOT_W + 2;

	localparam int SAT_MAX = 32767;
	localparam int SAT_MIN = -32768;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

endpackage

// ===== rtl/core/two_voice_sample_mixer_core.sv =====
`timescale 1ns / 1ps
// Two-voice sample mixer: looping background voice plus one-shot effect voice.
// Input stream s_axis carries one action per transfer (tuser) with its operands
// in tdata. Load actions write the internal sample store, start/stop/play
// actions change voice state, and each tick returns one mixed frame on m_axis.
// Non-tick actions return nothing. A tick reads both voices through the single
// port of the sample store, so the next action waits until the effect sample
// has been read. A tick's frame passes through the pipeline stages and the
// output queue before it is on m_axis.
// Frames land in a four-entry output queue; when the receiver stalls, ticks are
// accepted until four frames are outstanding, other actions stall with them.
// STORE_DEPTH must be a power of two; store addresses wrap modulo the depth.
// Reset clears voice state and the queue and loads the register defaults
// (music volume 50, effect volume 80, base 0, length 16384). The sample store
// is not cleared; entries are defined once written. The user must make
// configuration writes only while the block is idle; the block does not enforce it.
module two_voice_sample_mixer_core #(
	parameter int STORE_DEPTH = tvsm_pkg::DEF_STORE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tvsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tvsm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// start_address, clip_length, sample_value
	input  logic [tvsm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// action
	input  logic [tvsm_pkg::ACT_W-1:0]          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// left_sample, right_sample
	output logic [tvsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// music_active, effect_active
	output logic [tvsm_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
	import tvsm_pkg::*;
	`include "two_voice_sample_mixer_core_macros.svh"

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int PW = (AW > ADDR_IN_W + 2) ? AW : ADDR_IN_W + 2;

	typedef struct packed {
		logic             music_on;
		logic             effect_on;
		logic [VOL_W-1:0] music_vol;
		logic [VOL_W-1:0] effect_vol;
		logic             music_act;
		logic             effect_act;
	} tick_ctl_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                music_act;
		logic                effect_act;
	} frame_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		if (len == '0) begin
			r = LEN_W'(1);
		end else if (int'(len) > STORE_DEPTH) begin
			r = LEN_W'(STORE_DEPTH);
		end else begin
			r = len;
		end
		return r;
	endfunction

	// input fields
	logic [ACT_W-1:0]     act;
	logic [ADDR_IN_W-1:0] in_addr;
	logic [LEN_W-1:0]     in_len;
	logic [SAMPLE_W-1:0]  in_val;

	assign act     = s_axis_tuser;
	assign in_addr = s_axis_tdata[ADDR_IN_W-1:0];
	assign in_len  = s_axis_tdata[ADDR_IN_W +: LEN_W];
	assign in_val  = s_axis_tdata[ADDR_IN_W + LEN_W +: SAMPLE_W];

	// configuration and voice state
	logic [VOL_W-1:0]     music_vol_q, effect_vol_q;
	logic [ADDR_IN_W-1:0] music_base_q, effect_base_q;
	logic [LEN_W-1:0]     music_len_q, effect_len_q;
	logic [LEN_W-1:0]     music_pos_q, effect_pos_q;
	logic                 music_on_q, effect_on_q;
	logic                 busy_q;
	logic [FIFO_CNT_W-1:0] credits_q;

	logic in_fire, tick_fire, mem_we;
	logic [LEN_W-1:0] music_len_eff;
	logic [LEN_W:0]   music_pos_inc, effect_pos_inc;
	logic             music_wrap, effect_wrap;
	logic [PW-1:0]    music_sum, effect_sum, load_ext;
	logic [AW-1:0]    music_addr, effect_addr, load_addr, mem_addr;

	assign s_axis_tready = !busy_q && (credits_q < FIFO_CNT_W'(FIFO_DEPTH));
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign tick_fire = in_fire && (act == ACT_TICK);
	assign mem_we    = in_fire && (act == ACT_LOAD_SAMPLE);

	assign music_len_eff  = clamp_len(music_len_q);
	assign music_pos_inc  = {1'b0, music_pos_q} + (LEN_W + 1)'(1);
	assign effect_pos_inc = {1'b0, effect_pos_q} + (LEN_W + 1)'(1);
	assign music_wrap     = music_pos_inc >= {1'b0, music_len_eff};
	assign effect_wrap    = effect_pos_inc >= {1'b0, effect_len_q};

	assign music_sum   = PW'(music_base_q) + PW'(music_pos_q);
	assign effect_sum  = PW'(effect_base_q) + PW'(effect_pos_q);
	assign load_ext    = PW'(in_addr);
	assign music_addr  = music_sum[AW-1:0];
	assign effect_addr = effect_sum[AW-1:0];
	assign load_addr   = load_ext[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			music_vol_q   <= RST_MUSIC_VOLUME;
			effect_vol_q  <= RST_EFFECT_VOLUME;
			music_base_q  <= '0;
			music_len_q   <= RST_MUSIC_LENGTH;
			music_pos_q   <= '0;
			music_on_q    <= 1'b0;
			effect_on_q   <= 1'b0;
			effect_base_q <= '0;
			effect_len_q  <= LEN_W'(1);
			effect_pos_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MUSIC_VOLUME:  music_vol_q  <= cfg_wdata[VOL_W-1:0];
					CFG_EFFECT_VOLUME: effect_vol_q <= cfg_wdata[VOL_W-1:0];
					CFG_MUSIC_BASE:    music_base_q <= cfg_wdata[ADDR_IN_W-1:0];
					CFG_MUSIC_LENGTH:  music_len_q  <= cfg_wdata[LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_fire) begin
				unique case (act)
					ACT_TICK: begin
						if (music_on_q) begin
							music_pos_q <= music_wrap ? '0 : music_pos_inc[LEN_W-1:0];
						end
						if (effect_on_q) begin
							if (effect_wrap) begin
								effect_on_q  <= 1'b0;
								effect_pos_q <= '0;
							end else begin
								effect_pos_q <= effect_pos_inc[LEN_W-1:0];
							end
						end
					end
					ACT_START_MUSIC: begin
						if (!music_on_q) begin
							music_on_q  <= 1'b1;
							music_pos_q <= '0;
						end
					end
					ACT_STOP_MUSIC: begin
						music_on_q  <= 1'b0;
						music_pos_q <= '0;
					end
					ACT_PLAY_EFFECT: begin
						effect_base_q <= in_addr;
						effect_len_q  <= clamp_len(in_len);
						effect_pos_q  <= '0;
						effect_on_q   <= 1'b1;
					end
					ACT_STOP_EFFECT: begin
						effect_on_q  <= 1'b0;
						effect_pos_q <= '0;
					end
					ACT_STOP_ALL: begin
						music_on_q   <= 1'b0;
						music_pos_q  <= '0;
						effect_on_q  <= 1'b0;
						effect_pos_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// sample store: single port, one access per cycle
	logic [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	logic                valid_s1;
	tick_ctl_t           ctl_s1;
	logic [AW-1:0]       eaddr_s1;

	assign mem_addr = busy_q ? eaddr_s1 : (mem_we ? load_addr : music_addr);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sample_mem[mem_addr] <= in_val;
		end else begin
			rdata_q <= sample_mem[mem_addr];
		end
	end

	// stage 1: music sample in the read register, effect read issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			busy_q   <= tick_fire;
			valid_s1 <= tick_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			ctl_s1.music_on   <= music_on_q;
			ctl_s1.effect_on  <= effect_on_q;
			ctl_s1.music_vol  <= music_vol_q;
			ctl_s1.effect_vol <= effect_vol_q;
			ctl_s1.music_act  <= music_on_q;
			ctl_s1.effect_act <= effect_on_q && !effect_wrap;
			eaddr_s1          <= effect_addr;
		end
	end

	// stage 2: music sample captured
	logic                       valid_s2;
	tick_ctl_t                  ctl_s2;
	logic signed [SAMPLE_W-1:0] samp_m_s2;

	// stage 3: scaled products
	logic                     valid_s3;
	logic                     music_act_s3, effect_act_s3;
	logic signed [PROD_W-1:0] prod_m_s3, prod_e_s3;
	logic signed [PROD_W-1:0] mul_m, mul_e;
	logic signed [PROD_W-1:0] prod_m, prod_e;

	assign mul_m  = samp_m_s2 * $signed({1'b0, ctl_s2.music_vol});
	assign mul_e  = $signed(rdata_q) * $signed({1'b0, ctl_s2.effect_vol});
	assign prod_m = ctl_s2.music_on ? mul_m : '0;
	assign prod_e = ctl_s2.effect_on ? mul_e : '0;

	// stage 4: magnitudes divided by 100
	logic                          valid_s4;
	logic                          music_act_s4, effect_act_s4;
	logic                          neg_m_s4, neg_e_s4;
	logic [QUOT_W-1:0]             quot_m_s4, quot_e_s4;
	logic [MAG_W-1:0]              mag_m, mag_e;
	logic [MAG_W+RECIP_W-1:0]      scl_m, scl_e;

	assign mag_m = prod_m_s3[PROD_W-1] ? MAG_W'(-prod_m_s3) : MAG_W'(prod_m_s3);
	assign mag_e = prod_e_s3[PROD_W-1] ? MAG_W'(-prod_e_s3) : MAG_W'(prod_e_s3);
	assign scl_m = mag_m * RECIP_100;
	assign scl_e = mag_e * RECIP_100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2        <= ctl_s1;
		samp_m_s2     <= rdata_q;
		music_act_s3  <= ctl_s2.music_act;
		effect_act_s3 <= ctl_s2.effect_act;
		prod_m_s3     <= prod_m;
		prod_e_s3     <= prod_e;
		music_act_s4  <= music_act_s3;
		effect_act_s4 <= effect_act_s3;
		neg_m_s4      <= prod_m_s3[PROD_W-1];
		neg_e_s4      <= prod_e_s3[PROD_W-1];
		quot_m_s4     <= scl_m[RECIP_SHIFT +: QUOT_W];
		quot_e_s4     <= scl_e[RECIP_SHIFT +: QUOT_W];
	end

	// sum and saturate
	logic signed [QUOT_W:0]  sv_m, sv_e;
	logic signed [MIX_W-1:0] mix;
	logic [SAMPLE_W-1:0]     mix_sat;

	assign sv_m = neg_m_s4 ? -$signed({1'b0, quot_m_s4}) : $signed({1'b0, quot_m_s4});
	assign sv_e = neg_e_s4 ? -$signed({1'b0, quot_e_s4}) : $signed({1'b0, quot_e_s4});
	assign mix  = MIX_W'(sv_m) + MIX_W'(sv_e);

	always_comb begin
		if (mix > MIX_W'(SAT_MAX)) begin
			mix_sat = SAMPLE_W'(SAT_MAX);
		end else if (mix < MIX_W'(SAT_MIN)) begin
			mix_sat = SAMPLE_W'(SAT_MIN);
		end else begin
			mix_sat = mix[SAMPLE_W-1:0];
		end
	end

	// output queue
	frame_t                fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] fifo_cnt_q;
	logic                  fifo_wr, fifo_rd;
	frame_t                head;

	assign fifo_wr       = valid_s4;
	assign fifo_rd       = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = fifo_cnt_q != '0;
	assign head          = fifo_q[rd_ptr_q];
	assign m_axis_tdata  = {head.sample, head.sample};
	assign m_axis_tuser  = {head.effect_act, head.music_act};

	always_ff @(posedge clk) begin
		if (fifo_wr) begin
			fifo_q[wr_ptr_q] <= '{sample: mix_sat, music_act: music_act_s4,
				effect_act: effect_act_s4};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			credits_q  <= '0;
		end else begin
			if (fifo_wr) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (fifo_rd) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({fifo_wr, fifo_rd})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(1);
				2'b01:   fifo_cnt_q <= fifo_cnt_q - FIFO_CNT_W'(1);
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
			case ({tick_fire, fifo_rd})
				2'b10:   credits_q <= credits_q + FIFO_CNT_W'(1);
				2'b01:   credits_q <= credits_q - FIFO_CNT_W'(1);
				default: credits_q <= credits_q;
			endcase
		end
	end

	`TVSM_ASSERT_HOLDS(a_queue_within_credits, fifo_cnt_q <= credits_q,
		"output queue holds more frames than outstanding ticks")
	`TVSM_ASSERT_IMPLIES(a_busy_blocks_input, busy_q, valid_s1 && !s_axis_tready,
		"second store read without its tick or with input open")
	`TVSM_ASSERT_IMPLIES(a_no_queue_overflow, fifo_wr,
		(fifo_cnt_q < FIFO_CNT_W'(FIFO_DEPTH)) || fifo_rd,
		"frame written into a full output queue")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the two-voice sample mixer core, predicting frames per action
module testbench;
	import tvsm_pkg::*;

	localparam int STORE_DEPTH = DEF_STORE_DEPTH;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 140;
	localparam int WIN_BASE = STORE_DEPTH - 64;
	localparam int WIN_SPAN = 128;
	localparam int FILL_SPAN = 448;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

	typedef struct {
		logic [ACT_W-1:0]     action;
		logic [ADDR_IN_W-1:0] addr;
		logic [LEN_W-1:0]     len;
		logic [SAMPLE_W-1:0]  value;
		int                   gap;
	} mix_cmd_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic                music;
		logic                effect;
	} frame_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [ACT_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	two_voice_sample_mixer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// mixer image
	logic [SAMPLE_W-1:0] store_img [0:STORE_DEPTH-1];
	int music_vol = RST_MUSIC_VOLUME;
	int effect_vol = RST_EFFECT_VOLUME;
	int music_base = 0;
	int music_len = RST_MUSIC_LENGTH;
	int music_pos = 0;
	bit music_on = 1'b0;
	bit effect_on = 1'b0;
	int effect_base = 0;
	int effect_len = 1;
	int effect_pos = 0;

	mix_cmd_t pending [$];
	frame_t   frames_due [$];

	mix_cmd_t tx_cur;
	mix_cmd_t tx_shown;
	bit       tx_armed = 1'b0;
	bit       tx_next;
	int       tx_wait = 0;
	bit       in_taken = 1'b0;
	int       tx_max = 3;

	bit       rx_next;
	int       rx_wait = 0;
	bit       out_taken = 1'b0;
	int       rx_max = 3;
	bit       hold_go = 1'b0;
	int       hold_left = 0;

	frame_t   frame_got;
	frame_t   frame_want;
	int       frames_seen = 0;
	int       mismatches = 0;
	int       idle_cycles = 0;

	function automatic int clamp_len(input int len);
		if (len == 0) return 1;
		if (len > STORE_DEPTH) return STORE_DEPTH;
		return len;
	endfunction

	function automatic int scaled(input logic [SAMPLE_W-1:0] raw, input int vol);
		int s;
		s = $signed(raw);
		return (s * vol) / 100;
	endfunction

	// address in the filled region, which wraps past the top of the store
	function automatic int win_addr(input int span);
		return (WIN_BASE + $urandom_range(0, span - 1)) % STORE_DEPTH;
	endfunction

	task automatic mix_step(input mix_cmd_t c);
		int acc;
		frame_t f;
		acc = 0;
		case (c.action)
			ACT_TICK: begin
				if (music_on) begin
					acc += scaled(store_img[(music_base + music_pos) % STORE_DEPTH], music_vol);
					if (music_pos + 1 >= clamp_len(music_len)) music_pos = 0;
					else music_pos++;
				end
				if (effect_on) begin
					acc += scaled(store_img[(effect_base + effect_pos) % STORE_DEPTH], effect_vol);
					if (effect_pos + 1 >= effect_len) begin
						effect_on = 1'b0;
						effect_pos = 0;
					end else begin
						effect_pos++;
					end
				end
				if (acc > SAT_MAX) acc = SAT_MAX;
				else if (acc < SAT_MIN) acc = SAT_MIN;
				f.left = acc[SAMPLE_W-1:0];
				f.right = acc[SAMPLE_W-1:0];
				f.music = music_on;
				f.effect = effect_on;
				frames_due.push_back(f);
			end
			ACT_START_MUSIC: begin
				if (!music_on) begin
					music_on = 1'b1;
					music_pos = 0;
				end
			end
			ACT_STOP_MUSIC: begin
				music_on = 1'b0;
				music_pos = 0;
			end
			ACT_PLAY_EFFECT: begin
				effect_base = c.addr;
				effect_len = clamp_len(c.len);
				effect_pos = 0;
				effect_on = 1'b1;
			end
			ACT_STOP_EFFECT: begin
				effect_on = 1'b0;
				effect_pos = 0;
			end
			ACT_STOP_ALL: begin
				music_on = 1'b0;
				music_pos = 0;
				effect_on = 1'b0;
				effect_pos = 0;
			end
			ACT_LOAD_SAMPLE: store_img[c.addr] = c.value;
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		mismatches++;
		$display("mismatch in %s of frame %0d: got %0d, want %0d", field, frames_seen, got, want);
	endtask

	function automatic mix_cmd_t make_cmd(input logic [ACT_W-1:0] act, input int addr,
			input int len, input int val, input int gap);
		mix_cmd_t c;
		c.action = act;
		c.addr = addr[ADDR_IN_W-1:0];
		c.len = len[LEN_W-1:0];
		c.value = val[SAMPLE_W-1:0];
		c.gap = gap;
		return c;
	endfunction

	function automatic int rand_clip_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return $urandom_range(1, 40);
		if (r == 7) return 0;
		if (r == 8) return $urandom_range(STORE_DEPTH, 32767);
		return $urandom_range(0, 32767);
	endfunction

	function automatic mix_cmd_t rand_cmd();
		int r;
		int addr;
		logic [ACT_W-1:0] act;
		r = $urandom_range(0, 99);
		if (r < 55) act = ACT_TICK;
		else if (r < 63) act = ACT_START_MUSIC;
		else if (r < 67) act = ACT_STOP_MUSIC;
		else if (r < 77) act = ACT_PLAY_EFFECT;
		else if (r < 81) act = ACT_STOP_EFFECT;
		else if (r < 84) act = ACT_STOP_ALL;
		else if (r < 98) act = ACT_LOAD_SAMPLE;
		else act = ACT_UNUSED;
		addr = (act == ACT_LOAD_SAMPLE) ? win_addr(FILL_SPAN) : win_addr(WIN_SPAN);
		return make_cmd(act, addr, rand_clip_len(), $urandom, $urandom_range(0, tx_max));
	endfunction

	task automatic push_cmd(input logic [ACT_W-1:0] act, input int addr, input int len,
			input int val);
		pending.push_back(make_cmd(act, addr, len, val, $urandom_range(0, tx_max)));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		logic [CFG_DATA_W-1:0] v;
		v = val[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MUSIC_VOLUME:  music_vol = v[VOL_W-1:0];
			CFG_EFFECT_VOLUME: effect_vol = v[VOL_W-1:0];
			CFG_MUSIC_BASE:    music_base = v[ADDR_IN_W-1:0];
			CFG_MUSIC_LENGTH:  music_len = v[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drain();
		while (pending.size() != 0 || tx_armed || s_axis_tvalid || frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// driver: accepted transfer updates the image
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			mix_step(tx_shown);
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		tx_next = s_axis_tvalid;
		if (in_taken) begin
			in_taken = 1'b0;
			tx_next = 1'b0;
		end
		if (!tx_next && arst_n) begin
			if (!tx_armed && pending.size() != 0) begin
				tx_cur = pending.pop_front();
				tx_armed = 1'b1;
				tx_wait = tx_cur.gap;
			end
			if (tx_armed) begin
				if (tx_wait > 0) begin
					tx_wait--;
				end else begin
					tx_armed = 1'b0;
					tx_next = 1'b1;
					tx_shown = tx_cur;
					s_axis_tdata <= {3'b000, tx_cur.value, tx_cur.len, tx_cur.addr};
					s_axis_tuser <= tx_cur.action;
				end
			end
		end
		s_axis_tvalid <= tx_next;
	end

	// receiver with per-frame stall and long hold-off
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	always @(negedge clk) begin
		rx_next = m_axis_tready;
		if (out_taken) begin
			out_taken = 1'b0;
			rx_next = 1'b0;
			rx_wait = $urandom_range(0, rx_max);
		end
		if (hold_left != 0) begin
			rx_next = 1'b0;
		end else if (!rx_next) begin
			if (rx_wait > 0) rx_wait--;
			else rx_next = 1'b1;
		end
		m_axis_tready <= rx_next;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			out_taken = 1'b1;
			frame_got.left = m_axis_tdata[SAMPLE_W-1:0];
			frame_got.right = m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
			frame_got.music = m_axis_tuser[0];
			frame_got.effect = m_axis_tuser[1];
			if (frames_due.size() == 0) begin
				report_mismatch("frame with none due", $signed(frame_got.left), 0);
			end else begin
				frame_want = frames_due.pop_front();
				if (frame_got.left !== frame_want.left)
					report_mismatch("left_sample", $signed(frame_got.left),
						$signed(frame_want.left));
				if (frame_got.right !== frame_want.right)
					report_mismatch("right_sample", $signed(frame_got.right),
						$signed(frame_want.right));
				if (frame_got.music !== frame_want.music)
					report_mismatch("music_active", frame_got.music, frame_want.music);
				if (frame_got.effect !== frame_want.effect)
					report_mismatch("effect_active", frame_got.effect, frame_want.effect);
			end
			frames_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("testbench failed");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill the region that the voices read, so no read hits an unwritten entry
		for (int i = 0; i < FILL_SPAN; i++)
			pending.push_back(make_cmd(ACT_LOAD_SAMPLE, (WIN_BASE + i) % STORE_DEPTH,
				$urandom_range(0, 32767), $urandom, 0));

		// directed pass at reset register values
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_UNUSED, 16383, 32767, 32'hffff);
		push_cmd(ACT_LOAD_SAMPLE, 0, 1, 32'h7fff);
		push_cmd(ACT_LOAD_SAMPLE, 1, 1, 32'h8000);
		push_cmd(ACT_LOAD_SAMPLE, 16383, 1, 32'h8000);
		push_cmd(ACT_START_MUSIC, 0, 1, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_START_MUSIC, 0, 1, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_PLAY_EFFECT, 16383, 0, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_PLAY_EFFECT, 16383, 3, 0);
		push_cmd(ACT_STOP_MUSIC, 0, 1, 0);
		push_cmd(ACT_START_MUSIC, 0, 1, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_PLAY_EFFECT, 0, 32767, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_STOP_EFFECT, 0, 1, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_PLAY_EFFECT, 1, 2, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_STOP_ALL, 0, 1, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_START_MUSIC, 0, 1, 0);
		push_cmd(ACT_PLAY_EFFECT, 0, STORE_DEPTH, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		push_cmd(ACT_TICK, 0, 1, 0);
		wait_drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					tx_max = 18; rx_max = 18;
					write_reg(CFG_MUSIC_VOLUME, 100);
					write_reg(CFG_EFFECT_VOLUME, 100);
					write_reg(CFG_MUSIC_BASE, 16380);
					write_reg(CFG_MUSIC_LENGTH, 8);
				end
				1: begin
					tx_max = 0; rx_max = 18;
					write_reg(CFG_MUSIC_VOLUME, 0);
					write_reg(CFG_EFFECT_VOLUME, 127);
					write_reg(CFG_MUSIC_BASE, 0);
					write_reg(CFG_MUSIC_LENGTH, 0);
				end
				2: begin
					tx_max = 0; rx_max = 5;
					write_reg(CFG_MUSIC_VOLUME, 127);
					write_reg(CFG_EFFECT_VOLUME, 0);
					write_reg(CFG_MUSIC_BASE, win_addr(WIN_SPAN));
					write_reg(CFG_MUSIC_LENGTH, 32767);
				end
				3: begin
					tx_max = 0; rx_max = 0;
					write_reg(CFG_MUSIC_VOLUME, $urandom_range(0, 127));
					write_reg(CFG_EFFECT_VOLUME, $urandom_range(0, 127));
					write_reg(CFG_MUSIC_BASE, win_addr(WIN_SPAN));
					write_reg(CFG_MUSIC_LENGTH, $urandom_range(100, 300));
				end
				4: begin
					// shorter loop while the music position sits past its end
					tx_max = 18; rx_max = 0;
					write_reg(CFG_MUSIC_VOLUME, $urandom_range(0, 32767));
					write_reg(CFG_EFFECT_VOLUME, $urandom_range(0, 32767));
					write_reg(CFG_MUSIC_LENGTH, 2);
				end
				default: begin
					tx_max = 6; rx_max = 6;
					write_reg(CFG_MUSIC_VOLUME, $urandom_range(0, 32767));
					write_reg(CFG_EFFECT_VOLUME, $urandom_range(0, 32767));
					write_reg(CFG_MUSIC_BASE,
						win_addr(WIN_SPAN) + STORE_DEPTH * $urandom_range(0, 1));
					write_reg(CFG_MUSIC_LENGTH, $urandom_range(0, 32767));
				end
			endcase
			// effect reads stay near their start address
			push_cmd(ACT_STOP_EFFECT, 0, 1, 0);
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending.push_back(rand_cmd());
			if (p == 3) begin
				push_cmd(ACT_START_MUSIC, 0, 1, 0);
				for (int i = 0; i < 20; i++)
					push_cmd(ACT_TICK, 0, 1, 0);
			end
			if (p == 2) begin
				while (pending.size() > PHASE_ITEMS / 2) @(posedge clk);
				hold_go = 1'b1;
			end
			wait_drain();
		end

		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
